// ===== hdl/ssld_pkg.sv =====
// Shared types and constants for the sync/length deframer.
// Used by ssld_core and sync_seq_length_deframer; no dependencies.
`default_nettype none

package ssld_pkg;

  // Sync pair that opens every frame header.
  localparam logic [7:0] SYNC_HI = 8'hBE;
  localparam logic [7:0] SYNC_LO = 8'hEF;

  // Bytes in a header: two sync bytes, one sequence byte, three length bytes.
  localparam int unsigned HEADER_BYTES = 6;

  localparam int unsigned SKIP_W = 16;
  localparam int unsigned LEN_W  = 24;
  localparam logic [SKIP_W-1:0] SKIP_MAX = '1;

  // One result item as it leaves the deframer core.
  typedef struct packed {
    logic [7:0]        payload_byte;
    logic              first_of_frame;
    logic              last_of_frame;
    logic              empty_frame;
    logic [7:0]        frame_seq;
    logic              seq_gap;
    logic [SKIP_W-1:0] skipped_bytes;
  } ssld_result_t;

endpackage : ssld_pkg

`default_nettype wire

// ===== hdl/ssld_core.sv =====
// Header parser and payload tagger of the deframer: frame state and one-step update.
// Depends on ssld_pkg for the sync constants and the result struct.
`default_nettype none

module ssld_core
  import ssld_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire logic [7:0]   byte_i,
  output ssld_result_t      res_o,
  output logic              res_valid_o
);

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_SEQ   = 3'd2,
    PH_LEN0  = 3'd3,
    PH_LEN1  = 3'd4,
    PH_LEN2  = 3'd5,
    PH_DATA  = 3'd6
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [7:0]        expected_seq_q, expected_seq_d;
  logic [LEN_W-1:0]  bytes_left_q, bytes_left_d;
  logic [15:0]       length_shift_q, length_shift_d;
  logic [SKIP_W-1:0] skip_count_q, skip_count_d;
  logic [7:0]        header_seq_q, header_seq_d;
  logic              gap_seen_q, gap_seen_d;
  logic              first_pending_q, first_pending_d;

  logic [SKIP_W:0]   skip_sum;
  logic [1:0]        skip_inc;
  logic [SKIP_W-1:0] skip_sat;
  logic [LEN_W-1:0]  full_len;
  logic              last_byte;

  // Saturating add of the bytes skipped in this step.
  assign skip_sum = {1'b0, skip_count_q} + {{(SKIP_W-1){1'b0}}, skip_inc};
  assign skip_sat = skip_sum[SKIP_W] ? SKIP_MAX : skip_sum[SKIP_W-1:0];
  assign full_len = {length_shift_q, byte_i};
  assign last_byte = (bytes_left_q <= LEN_W'(1));

  // Next state and result for the byte being processed.
  always_comb begin
    phase_d         = phase_q;
    expected_seq_d  = expected_seq_q;
    bytes_left_d    = bytes_left_q;
    length_shift_d  = length_shift_q;
    skip_count_d    = skip_count_q;
    header_seq_d    = header_seq_q;
    gap_seen_d      = gap_seen_q;
    first_pending_d = first_pending_q;
    skip_inc        = 2'd0;
    res_valid_o     = 1'b0;
    res_o.payload_byte   = byte_i;
    res_o.first_of_frame = first_pending_q;
    res_o.last_of_frame  = last_byte;
    res_o.empty_frame    = 1'b0;
    res_o.frame_seq      = header_seq_q;
    res_o.seq_gap        = gap_seen_q;
    res_o.skipped_bytes  = skip_count_q;

    case (phase_q)
      PH_HUNT2: begin
        if (byte_i == SYNC_LO) begin
          phase_d = PH_SEQ;
        end else if (byte_i == SYNC_HI) begin
          // The earlier sync byte is dropped; this one may start the pair.
          skip_inc     = 2'd1;
          skip_count_d = skip_sat;
        end else begin
          skip_inc     = 2'd2;
          skip_count_d = skip_sat;
          phase_d      = PH_HUNT1;
        end
      end
      PH_SEQ: begin
        header_seq_d   = byte_i;
        gap_seen_d     = (byte_i != expected_seq_q);
        expected_seq_d = byte_i + 8'd1;
        phase_d        = PH_LEN0;
      end
      PH_LEN0: begin
        length_shift_d = {8'd0, byte_i};
        phase_d        = PH_LEN1;
      end
      PH_LEN1: begin
        length_shift_d = {length_shift_q[7:0], byte_i};
        phase_d        = PH_LEN2;
      end
      PH_LEN2: begin
        length_shift_d = full_len[15:0];
        if (full_len == '0) begin
          // Empty frame: a single marker result.
          res_valid_o          = 1'b1;
          res_o.payload_byte   = 8'd0;
          res_o.first_of_frame = 1'b1;
          res_o.last_of_frame  = 1'b1;
          res_o.empty_frame    = 1'b1;
          skip_count_d         = '0;
          phase_d              = PH_HUNT1;
        end else begin
          bytes_left_d    = full_len;
          first_pending_d = 1'b1;
          phase_d         = PH_DATA;
        end
      end
      PH_DATA: begin
        res_valid_o     = 1'b1;
        first_pending_d = 1'b0;
        if (last_byte) begin
          bytes_left_d = '0;
          skip_count_d = '0;
          phase_d      = PH_HUNT1;
        end else begin
          bytes_left_d = bytes_left_q - LEN_W'(1);
        end
      end
      default: begin
        // Hunt for the first sync byte; unused codes land here too.
        if (byte_i == SYNC_HI) begin
          phase_d = PH_HUNT2;
        end else begin
          skip_inc     = 2'd1;
          skip_count_d = skip_sat;
          phase_d      = PH_HUNT1;
        end
      end
    endcase

    if (!step_i) begin
      res_valid_o = 1'b0;
    end
  end

  // Frame state, updated only when a byte is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_HUNT1;
      expected_seq_q  <= '0;
      bytes_left_q    <= '0;
      length_shift_q  <= '0;
      skip_count_q    <= '0;
      header_seq_q    <= '0;
      gap_seen_q      <= 1'b0;
      first_pending_q <= 1'b0;
    end else if (step_i) begin
      phase_q         <= phase_d;
      expected_seq_q  <= expected_seq_d;
      bytes_left_q    <= bytes_left_d;
      length_shift_q  <= length_shift_d;
      skip_count_q    <= skip_count_d;
      header_seq_q    <= header_seq_d;
      gap_seen_q      <= gap_seen_d;
      first_pending_q <= first_pending_d;
    end
  end

endmodule : ssld_core

`default_nettype wire

// ===== hdl/sync_seq_length_deframer.sv =====
// Top level of the sync/length deframer: input register, core and result register.
// Depends on ssld_pkg and ssld_core.
//
// Usage:
//   The slave stream carries one link byte per transaction in s_axis_tdata.
//   The block hunts for the sync pair 0xBE 0xEF, reads a sequence byte and a
//   24-bit big-endian length, then forwards the payload bytes on the master
//   stream, tagged with the frame sequence, a sequence-gap flag and the count
//   of bytes skipped while hunting. A zero-length frame gives one transaction
//   with the empty flag set. Header bytes give no output transaction.
//   An accepted byte passes the input register and then the result register
//   before reaching the master side. Throughput is one byte per cycle while
//   the receiver does not stall; the frame state is updated between the two.
//   When the receiver stalls, the result register holds its transaction and
//   the input register holds one more byte; s_axis_tready then drops until
//   the master side drains. Reset clears the frame state to the hunt for the
//   first sync byte, the expected sequence to zero and both registers to empty.
`default_nettype none

module sync_seq_length_deframer
  import ssld_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] payload_byte, [15:8] frame_seq,
                                           // [31:16] skipped_bytes
  output logic             m_axis_tlast,   // last_of_frame
  output logic [2:0]       m_axis_tuser    // [0] first_of_frame, [1] empty_frame,
                                           // [2] seq_gap
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  ssld_result_t out_res_q;
  logic         out_free;
  logic         step;
  ssld_result_t core_res;
  logic         core_res_valid;

  // The result register can load when empty or when its transaction leaves.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  ssld_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_o       (core_res),
    .res_valid_o (core_res_valid)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= core_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && core_res_valid) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.skipped_bytes, out_res_q.frame_seq,
                          out_res_q.payload_byte};
  assign m_axis_tlast  = out_res_q.last_of_frame;
  assign m_axis_tuser  = {out_res_q.seq_gap, out_res_q.empty_frame,
                          out_res_q.first_of_frame};

  // An empty-frame marker is always both first and last of its frame.
  a_empty_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] && m_axis_tlast)
    else $error("empty frame result without first and last marks");

  // A buffered byte is kept while the result register is blocked.
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(in_byte_q))
    else $error("input register lost a byte during a stall");

  // With the result register empty, the input side never stalls.
  a_ready_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

endmodule : sync_seq_length_deframer

`default_nettype wire
